FILE: sv/gb2312_text_layout_macros.svh
// ---------------------------------------------------------------------------
// GB2312 text layout assertion macros
// Shared property shapes for the layout block's checks.
// ---------------------------------------------------------------------------
`ifndef GB2312_TEXT_LAYOUT_MACROS_SVH
`define GB2312_TEXT_LAYOUT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define G2TL_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("text layout check failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define G2TL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("text layout check failed");

`endif

FILE: sv/g2tl_pkg.sv
// ---------------------------------------------------------------------------
// GB2312 text layout package
// Codes, byte ranges and the digit-map lookup used by the layout block.
// ---------------------------------------------------------------------------
package g2tl_pkg;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_ASCII = 2'd0,
      KIND_BLANK = 2'd1,
      KIND_CJK   = 2'd2
   } glyph_kind_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_START_COL  = 3'd0,
      CSR_START_ROW  = 3'd1,
      CSR_GLYPH_SIZE = 3'd2,
      CSR_LINE_WIDTH = 3'd3,
      CSR_FONT_BASE  = 3'd4
   } csr_index_type;

   // Byte ranges
   localparam logic [7:0] LEAD_LO    = 8'hA1;
   localparam logic [7:0] LEAD_HI    = 8'hF7;
   localparam logic [7:0] TRAIL_LO   = 8'hA1;
   localparam logic [7:0] TRAIL_HI   = 8'hFE;
   localparam logic [7:0] PRINT_LO   = 8'h20;
   localparam logic [7:0] PRINT_HI   = 8'h7E;
   localparam logic [7:0] NEWLINE    = 8'h0A;

   // Glyph count of the ASCII table that precedes the Chinese table
   localparam logic [6:0] ASCII_GLYPHS = 7'd95;

   // Register reset values
   localparam logic [7:0]  GLYPH_SIZE_RESET = 8'd16;
   localparam logic [15:0] LINE_WIDTH_RESET = 16'd240;

   // Sizes that use the digit map
   function automatic logic is_large_font(input logic [7:0] size);
      return (size == 8'd54) || (size == 8'd64) || (size == 8'd76);
   endfunction

   // Position in "0123456789: -", with a found flag in the top bit
   function automatic logic [4:0] digit_lookup(input logic [7:0] b);
      logic [4:0] r;
      case (b)
         8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
         8'h35, 8'h36, 8'h37, 8'h38, 8'h39: r = {1'b1, b[3:0]};
         8'h3A: r = {1'b1, 4'd10};
         8'h20: r = {1'b1, 4'd11};
         8'h2D: r = {1'b1, 4'd12};
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // Result item; pos_x sits in the lowest bits
   typedef struct packed {
      glyph_kind_type glyph_kind;
      logic [12:0]    glyph_bytes;
      logic [23:0]    glyph_addr;
      logic [15:0]    char_code;
      logic [7:0]     glyph_width;
      logic [15:0]    pos_y;
      logic [15:0]    pos_x;
   } result_type;

endpackage

FILE: sv/gb2312_text_layout.sv
// ---------------------------------------------------------------------------
// GB2312 text layout
// Turns a byte stream of ASCII and GB2312 text into glyph placement items.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one text byte per item (tdata) with a string-start flag
//   (tuser). Each printable ASCII byte, or each GB2312 lead/trail pair,
//   yields one rsp_* item with the glyph kind (tuser) and its position,
//   width, code, flash address and bitmap size (tdata). Lead bytes,
//   newline and ignored bytes yield no item.
//   csr_* writes the layout registers by index; it is always ready and a
//   write takes effect for the next accepted byte.
// Timing:
//   One byte per cycle while the skid register is empty. Each result is
//   registered. The cursor update is a single add/compare/select path
//   from the cursor registers back to themselves, which sets the rate.
// Reset and stall:
//   Synchronous reset clears the cursor, the pending lead and the output
//   stages and loads the register defaults. A stalled rsp_* side fills the
//   two-entry output stage (result register plus skid register); req_tready
//   drops only once the skid register holds an item.
// ---------------------------------------------------------------------------
`include "gb2312_text_layout_macros.svh"

module gb2312_text_layout
   import g2tl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tuser,   // [0] string_start
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [15:0] pos_x, [31:16] pos_y, [39:32] glyph_width,
                                    // [55:40] char_code, [79:56] glyph_addr,
                                    // [92:80] glyph_bytes, [95:93] zero
   output logic [1:0]  rsp_tuser,   // [1:0] glyph_kind
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   // Layout registers and values derived from the glyph size
   logic [15:0] start_col_ff, start_row_ff, line_width_ff;
   logic [7:0]  glyph_size_ff;
   logic [23:0] font_base_ff;
   logic [11:0] ascii_bytes_ff;
   logic [12:0] cjk_bytes_ff;

   // Cursor state
   logic [15:0] cursor_x_ff, cursor_x_in, cursor_y_ff, cursor_y_in;
   logic [7:0]  lead_byte_ff, lead_byte_in;
   logic        lead_pending_ff, lead_pending_in;

   // Output stage
   result_type  rsp_data_ff, rsp_data_in, skid_data_ff, skid_data_in;
   logic        rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;

   // Datapath
   logic        req_fire, csr_fire;
   logic [7:0]  b;
   logic [15:0] cx0, cy0, px, py, step_y;
   logic        lp;
   logic        is_trail, is_lead, is_print, is_nl, is_cjk, is_glyph;
   logic [7:0]  w;
   logic        wrap;
   logic [4:0]  digit;
   logic        map_font, found;
   logic [6:0]  idx;
   logic [18:0] idx_off, cjk_off;
   logic [23:0] ascii_addr, cjk_addr;
   logic [11:0] ascii_bytes_new;
   logic [12:0] cjk_bytes_new;
   result_type  res;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;

   // Bitmap sizes for a new glyph size
   assign ascii_bytes_new = {4'd0, csr_wdata[7:0]} *
                            {7'd0, 5'(({1'b0, csr_wdata[7:1]} + 8'd7) >> 3)};
   assign cjk_bytes_new   = {5'd0, csr_wdata[7:0]} *
                            {7'd0, 6'(({1'b0, csr_wdata[7:0]} + 9'd7) >> 3)};

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_col_ff   <= '0;
         start_row_ff   <= '0;
         glyph_size_ff  <= GLYPH_SIZE_RESET;
         ascii_bytes_ff <= 12'(GLYPH_SIZE_RESET * ((GLYPH_SIZE_RESET / 2 + 7) / 8));
         cjk_bytes_ff   <= 13'(GLYPH_SIZE_RESET * ((GLYPH_SIZE_RESET + 7) / 8));
         line_width_ff  <= LINE_WIDTH_RESET;
         font_base_ff   <= '0;
      end else if (csr_fire) begin
         case (csr_index_type'(csr_index))
            CSR_START_COL:  start_col_ff <= csr_wdata[15:0];
            CSR_START_ROW:  start_row_ff <= csr_wdata[15:0];
            CSR_GLYPH_SIZE: begin
               glyph_size_ff  <= csr_wdata[7:0];
               ascii_bytes_ff <= ascii_bytes_new;
               cjk_bytes_ff   <= cjk_bytes_new;
            end
            CSR_LINE_WIDTH: line_width_ff <= csr_wdata[15:0];
            CSR_FONT_BASE:  font_base_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Decode the byte against the cursor after a string start
   always_comb begin
      b        = req_tdata;
      cx0      = req_tuser ? start_col_ff : cursor_x_ff;
      cy0      = req_tuser ? start_row_ff : cursor_y_ff;
      lp       = !req_tuser && lead_pending_ff;
      is_trail = (b >= TRAIL_LO) && (b <= TRAIL_HI);
      is_lead  = (b >= LEAD_LO) && (b <= LEAD_HI);
      is_print = (b >= PRINT_LO) && (b <= PRINT_HI);
      is_nl    = (b == NEWLINE);
      is_cjk   = lp && is_trail;
      is_glyph = is_cjk || (!is_lead && is_print);
      w        = is_cjk ? glyph_size_ff : {1'b0, glyph_size_ff[7:1]};

      // Wrap before a glyph that would cross the line width
      step_y = cy0 + {8'd0, glyph_size_ff};
      wrap   = ({1'b0, cx0} + {9'd0, w}) > {1'b0, line_width_ff};
      px     = wrap ? start_col_ff : cx0;
      py     = wrap ? step_y : cy0;

      // Glyph index and flash addresses
      map_font   = is_large_font(glyph_size_ff);
      digit      = digit_lookup(b);
      found      = !map_font || digit[4];
      idx        = map_font ? {3'd0, digit[3:0]} : 7'(b - PRINT_LO);
      idx_off    = {12'd0, idx} * {7'd0, ascii_bytes_ff};
      cjk_off    = {12'd0, ASCII_GLYPHS} * {7'd0, ascii_bytes_ff};
      ascii_addr = font_base_ff + {5'd0, idx_off};
      cjk_addr   = font_base_ff + {5'd0, cjk_off};

      // Build the result
      res.pos_x       = px;
      res.pos_y       = py;
      res.glyph_width = w;
      if (is_cjk) begin
         res.glyph_kind  = KIND_CJK;
         res.char_code   = {lead_byte_ff, b};
         res.glyph_addr  = cjk_addr;
         res.glyph_bytes = cjk_bytes_ff;
      end else begin
         res.glyph_kind  = found ? KIND_ASCII : KIND_BLANK;
         res.char_code   = {8'd0, b};
         res.glyph_addr  = found ? ascii_addr : 24'd0;
         res.glyph_bytes = {1'b0, ascii_bytes_ff};
      end

      // Next cursor and lead state
      lead_pending_in = lead_pending_ff;
      lead_byte_in    = lead_byte_ff;
      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      if (req_fire) begin
         lead_pending_in = !is_cjk && is_lead;
         lead_byte_in    = (!is_cjk && is_lead) ? b : 8'd0;
         if (is_glyph) begin
            cursor_x_in = px + {8'd0, w};
            cursor_y_in = py;
         end else if (!is_lead && is_nl) begin
            cursor_x_in = start_col_ff;
            cursor_y_in = step_y;
         end else begin
            cursor_x_in = cx0;
            cursor_y_in = cy0;
         end
      end
   end

   // Output stage: pop to the receiver, refill from skid, then push
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in  = skid_valid_ff;
         rsp_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      if (req_fire && is_glyph) begin
         if (!rsp_valid_in) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res;
         end
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff     <= '0;
         cursor_y_ff     <= '0;
         lead_byte_ff    <= '0;
         lead_pending_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         cursor_x_ff     <= cursor_x_in;
         cursor_y_ff     <= cursor_y_in;
         lead_byte_ff    <= lead_byte_in;
         lead_pending_ff <= lead_pending_in;
         rsp_valid_ff    <= rsp_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.glyph_kind;
   assign rsp_tdata  = {3'd0, rsp_data_ff.glyph_bytes, rsp_data_ff.glyph_addr,
                        rsp_data_ff.char_code, rsp_data_ff.glyph_width,
                        rsp_data_ff.pos_y, rsp_data_ff.pos_x};

   // Checks
   `G2TL_ASSERT_SAME(a_skid_behind_rsp, skid_valid_ff, rsp_valid_ff)
   `G2TL_ASSERT_SAME(a_lead_in_range, lead_pending_ff, (lead_byte_ff >= LEAD_LO) && (lead_byte_ff <= LEAD_HI))
   `G2TL_ASSERT_SAME(a_no_stale_lead, !lead_pending_ff, lead_byte_ff == 8'd0)
   `G2TL_ASSERT_NEXT(a_stall_fills_skid, req_fire && is_glyph && rsp_valid_ff && !rsp_tready, skid_valid_ff)

endmodule
